// ===== rtl/fvdc_pkg.sv =====
// Shared types and constants of the fifth-order diagram counter.
`timescale 1ns / 1ps

package fvdc_pkg;

  // Input coordinate and result field widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 40;

  // A pair difference is a sum of up to four steps
  localparam int DIFF_W = IN_W + 2;
  // The square of a pair difference is non-negative and at most 2^(2*DIFF_W-2)
  localparam int SQ_W   = 2 * DIFF_W - 1;
  // Sum of three squares
  localparam int SUM_W  = SQ_W + 2;

  // Counter slots, in result order
  localparam int CNT_RING            = 0;
  localparam int CNT_RING_C03        = 1;
  localparam int CNT_DIAMOND         = 2;
  localparam int CNT_RING_C03_24     = 3;
  localparam int CNT_RING_C02_24     = 4;
  localparam int CNT_DIAMOND_C13     = 5;
  localparam int CNT_RING_3C         = 6;
  localparam int CNT_RING_C02_24_13  = 7;
  localparam int CNT_RING_4C         = 8;
  localparam int CNT_COMPLETE        = 9;
  localparam int CNT_SAMPLES         = 10;
  localparam int NUM_CNT             = 11;

  typedef logic signed [IN_W-1:0] fvdc_coord_t;

  typedef struct packed {
    fvdc_coord_t x;
    fvdc_coord_t y;
    fvdc_coord_t z;
  } fvdc_vec_t;

  // Four displacements, index 0 is the first step
  typedef fvdc_vec_t [3:0] fvdc_steps_t;

  // Overlap flags of the six pairs that the diagrams use
  typedef struct packed {
    logic l02;
    logic l03;
    logic l04;
    logic l13;
    logic l14;
    logic l24;
  } fvdc_links_t;

  typedef struct packed {
    logic        valid;
    fvdc_links_t links;
  } fvdc_link_item_t;

  typedef logic [NUM_CNT-1:0][OUT_W-1:0] fvdc_counts_t;

endpackage

// ===== rtl/fvdc_step_if.sv =====
// Sample channel: four displacement vectors with valid/ready.
`timescale 1ns / 1ps

interface fvdc_step_if;
  logic                           valid;
  logic                           ready;
  logic signed [fvdc_pkg::IN_W-1:0] step1_x;
  logic signed [fvdc_pkg::IN_W-1:0] step1_y;
  logic signed [fvdc_pkg::IN_W-1:0] step1_z;
  logic signed [fvdc_pkg::IN_W-1:0] step2_x;
  logic signed [fvdc_pkg::IN_W-1:0] step2_y;
  logic signed [fvdc_pkg::IN_W-1:0] step2_z;
  logic signed [fvdc_pkg::IN_W-1:0] step3_x;
  logic signed [fvdc_pkg::IN_W-1:0] step3_y;
  logic signed [fvdc_pkg::IN_W-1:0] step3_z;
  logic signed [fvdc_pkg::IN_W-1:0] step4_x;
  logic signed [fvdc_pkg::IN_W-1:0] step4_y;
  logic signed [fvdc_pkg::IN_W-1:0] step4_z;

  modport source (
    output valid, step1_x, step1_y, step1_z, step2_x, step2_y, step2_z,
           step3_x, step3_y, step3_z, step4_x, step4_y, step4_z,
    input  ready
  );

  modport sink (
    input  valid, step1_x, step1_y, step1_z, step2_x, step2_y, step2_z,
           step3_x, step3_y, step3_z, step4_x, step4_y, step4_z,
    output ready
  );
endinterface

// ===== rtl/fvdc_count_if.sv =====
// Result channel: the eleven counter values with valid/ready.
`timescale 1ns / 1ps

interface fvdc_count_if;
  logic                        valid;
  logic                        ready;
  logic [fvdc_pkg::OUT_W-1:0]  ring_count;
  logic [fvdc_pkg::OUT_W-1:0]  ring_chord03_count;
  logic [fvdc_pkg::OUT_W-1:0]  diamond_count;
  logic [fvdc_pkg::OUT_W-1:0]  ring_chord03_24_count;
  logic [fvdc_pkg::OUT_W-1:0]  ring_chord02_24_count;
  logic [fvdc_pkg::OUT_W-1:0]  diamond_chord13_count;
  logic [fvdc_pkg::OUT_W-1:0]  ring_three_chord_count;
  logic [fvdc_pkg::OUT_W-1:0]  ring_chord02_24_13_count;
  logic [fvdc_pkg::OUT_W-1:0]  ring_four_chord_count;
  logic [fvdc_pkg::OUT_W-1:0]  complete_count;
  logic [fvdc_pkg::OUT_W-1:0]  samples_seen;

  modport source (
    output valid, ring_count, ring_chord03_count, diamond_count,
           ring_chord03_24_count, ring_chord02_24_count, diamond_chord13_count,
           ring_three_chord_count, ring_chord02_24_13_count,
           ring_four_chord_count, complete_count, samples_seen,
    input  ready
  );

  modport sink (
    input  valid, ring_count, ring_chord03_count, diamond_count,
           ring_chord03_24_count, ring_chord02_24_count, diamond_chord13_count,
           ring_three_chord_count, ring_chord02_24_13_count,
           ring_four_chord_count, complete_count, samples_seen,
    output ready
  );
endinterface

// ===== rtl/fifth_virial_diagram_counter_unit.sv =====
// Top level of the fifth-order Mayer-diagram hit counter.
`timescale 1ns / 1ps

// Usage:
//   step_i carries one Monte Carlo sample per item: four signed displacement
//   vectors (FRAC_BITS fraction bits). The block chains them into five sphere
//   centres from the origin, tests six pairs for squared distance below one,
//   and bumps the matching diagram counters plus the sample counter.
//   count_o returns one item per sample: all eleven counters as they stand
//   right after that sample's update, saturated at 2^COUNT_BITS - 1 and shown
//   in 40-bit fields.
// Throughput: one item per cycle while count_o is ready. Each step is a register stage:
//   input register, pair differences, squares (one 18x18 multiply each),
//   sum and compare, then the counter bank, whose registers are the result.
// Path: a sample moves from the input register through the pair-difference,
//   square and compare registers into the counter bank, which makes the result valid.
// Stall: every stage has its own valid bit, so bubbles close up and step_i
//   keeps accepting until the four stages ahead of the result fill up; a held
//   result keeps its counters frozen until taken.
// Reset: rst_ni clears all counters and all stage valids at once; the block
//   is ready to take items as soon as reset is released.

module fifth_virial_diagram_counter_unit #(
  parameter int COUNT_BITS = 40,
  parameter int FRAC_BITS  = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fvdc_step_if.sink           step_i,
  fvdc_count_if.source        count_o
);

  fvdc_pkg::fvdc_steps_t     steps;
  fvdc_pkg::fvdc_link_item_t link;
  fvdc_pkg::fvdc_counts_t    counts;
  logic                      bank_ready;

  // Gather the displacements, first step at index zero
  always_comb begin
    steps      = '0;
    steps[0].x = step_i.step1_x;
    steps[0].y = step_i.step1_y;
    steps[0].z = step_i.step1_z;
    steps[1].x = step_i.step2_x;
    steps[1].y = step_i.step2_y;
    steps[1].z = step_i.step2_z;
    steps[2].x = step_i.step3_x;
    steps[2].y = step_i.step3_y;
    steps[2].z = step_i.step3_z;
    steps[3].x = step_i.step4_x;
    steps[3].y = step_i.step4_y;
    steps[3].z = step_i.step4_z;
  end

  fvdc_link_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_link_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (step_i.valid),
    .ready_o (step_i.ready),
    .steps_i (steps),
    .link_o  (link),
    .ready_i (bank_ready)
  );

  fvdc_counter_bank #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counter_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .link_i  (link),
    .ready_o (bank_ready),
    .valid_o (count_o.valid),
    .ready_i (count_o.ready),
    .count_o (counts)
  );

  // Spread the counter slots onto the named result fields
  assign count_o.ring_count               = counts[fvdc_pkg::CNT_RING];
  assign count_o.ring_chord03_count       = counts[fvdc_pkg::CNT_RING_C03];
  assign count_o.diamond_count            = counts[fvdc_pkg::CNT_DIAMOND];
  assign count_o.ring_chord03_24_count    = counts[fvdc_pkg::CNT_RING_C03_24];
  assign count_o.ring_chord02_24_count    = counts[fvdc_pkg::CNT_RING_C02_24];
  assign count_o.diamond_chord13_count    = counts[fvdc_pkg::CNT_DIAMOND_C13];
  assign count_o.ring_three_chord_count   = counts[fvdc_pkg::CNT_RING_3C];
  assign count_o.ring_chord02_24_13_count = counts[fvdc_pkg::CNT_RING_C02_24_13];
  assign count_o.ring_four_chord_count    = counts[fvdc_pkg::CNT_RING_4C];
  assign count_o.complete_count           = counts[fvdc_pkg::CNT_COMPLETE];
  assign count_o.samples_seen             = counts[fvdc_pkg::CNT_SAMPLES];

endmodule

// ===== rtl/fvdc_link_pipe.sv =====
// Overlap test pipeline: input register, pair differences, squares, compare.
`timescale 1ns / 1ps

module fvdc_link_pipe #(
  parameter int FRAC_BITS = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  fvdc_pkg::fvdc_steps_t     steps_i,
  output fvdc_pkg::fvdc_link_item_t link_o,
  input  logic                      ready_i
);

  localparam int NUM_PAIRS = 6;
  localparam int P02 = 0;
  localparam int P03 = 1;
  localparam int P04 = 2;
  localparam int P13 = 3;
  localparam int P14 = 4;
  localparam int P24 = 5;

  // Compare width covers both the square sum and the threshold 1 << 2*FRAC_BITS
  localparam int THR_W = 2 * FRAC_BITS + 1;
  localparam int CMP_W = (THR_W > fvdc_pkg::SUM_W) ? THR_W : fvdc_pkg::SUM_W;
  localparam logic [CMP_W-1:0] ONE_SQ = CMP_W'(1) << (2 * FRAC_BITS);

  // Stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Payload registers
  fvdc_pkg::fvdc_steps_t            steps_q;
  logic signed [fvdc_pkg::IN_W-1:0]   st     [4][3];
  logic signed [fvdc_pkg::DIFF_W-1:0] ext    [4][3];
  logic signed [fvdc_pkg::DIFF_W-1:0] diff_d [NUM_PAIRS][3];
  logic signed [fvdc_pkg::DIFF_W-1:0] diff_q [NUM_PAIRS][3];
  logic signed [2*fvdc_pkg::DIFF_W-1:0] prod [NUM_PAIRS][3];
  logic [fvdc_pkg::SQ_W-1:0]          sq_q   [NUM_PAIRS][3];
  logic [fvdc_pkg::SUM_W-1:0]         sum    [NUM_PAIRS];
  logic [NUM_PAIRS-1:0]               lt;
  fvdc_pkg::fvdc_links_t              links_d;
  fvdc_pkg::fvdc_links_t              links_q;

  for (genvar s = 0; s < 4; s++) begin : g_unpack
    assign st[s][0] = steps_q[s].x;
    assign st[s][1] = steps_q[s].y;
    assign st[s][2] = steps_q[s].z;
    for (genvar k = 0; k < 3; k++) begin : g_ext
      assign ext[s][k] = fvdc_pkg::DIFF_W'(st[s][k]);
    end
  end

  // Centre j minus centre i is the sum of steps i+1 .. j
  for (genvar k = 0; k < 3; k++) begin : g_diff
    assign diff_d[P02][k] = ext[0][k] + ext[1][k];
    assign diff_d[P03][k] = ext[0][k] + ext[1][k] + ext[2][k];
    assign diff_d[P04][k] = ext[0][k] + ext[1][k] + ext[2][k] + ext[3][k];
    assign diff_d[P13][k] = ext[1][k] + ext[2][k];
    assign diff_d[P14][k] = ext[1][k] + ext[2][k] + ext[3][k];
    assign diff_d[P24][k] = ext[2][k] + ext[3][k];
  end

  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    for (genvar k = 0; k < 3; k++) begin : g_axis
      assign prod[p][k] = diff_q[p][k] * diff_q[p][k];

      always_ff @(posedge clk_i) begin
        if (en2) diff_q[p][k] <= diff_d[p][k];
        if (en3) sq_q[p][k]   <= prod[p][k][fvdc_pkg::SQ_W-1:0];
      end
    end

    assign sum[p] = fvdc_pkg::SUM_W'(sq_q[p][0]) + fvdc_pkg::SUM_W'(sq_q[p][1])
                  + fvdc_pkg::SUM_W'(sq_q[p][2]);
    // Strictly below one: touching spheres do not overlap
    assign lt[p]  = CMP_W'(sum[p]) < ONE_SQ;
  end

  always_comb begin
    links_d     = '0;
    links_d.l02 = lt[P02];
    links_d.l03 = lt[P03];
    links_d.l04 = lt[P04];
    links_d.l13 = lt[P13];
    links_d.l14 = lt[P14];
    links_d.l24 = lt[P24];
  end

  always_ff @(posedge clk_i) begin
    if (en1) steps_q <= steps_i;
    if (en4) links_q <= links_d;
  end

  assign link_o.valid = v4_q;
  assign link_o.links = links_q;

  // A stalled link result must stay put
  a_link_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !ready_i) |=> (v4_q && $stable(links_q)))
    else $error("link stage changed while stalled");

endmodule

// ===== rtl/fvdc_counter_bank.sv =====
// Saturating diagram and sample counters; the counter registers are the result.
`timescale 1ns / 1ps

module fvdc_counter_bank #(
  parameter int COUNT_BITS = 40
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  fvdc_pkg::fvdc_link_item_t link_i,
  output logic                      ready_o,
  output logic                      valid_o,
  input  logic                      ready_i,
  output fvdc_pkg::fvdc_counts_t    count_o
);

  localparam int NC = fvdc_pkg::NUM_CNT;
  localparam int OW = fvdc_pkg::OUT_W;

  logic                          valid_q;
  logic                          take;
  logic [NC-1:0]                 hit;
  logic [NC-1:0][COUNT_BITS-1:0] cnt_q;
  logic [NC-1:0][COUNT_BITS-1:0] cnt_d;
  fvdc_pkg::fvdc_links_t         l;

  assign ready_o = !valid_q || ready_i;
  assign take    = link_i.valid && ready_o;
  assign valid_o = valid_q;
  assign l       = link_i.links;

  always_comb begin
    hit = '0;
    hit[fvdc_pkg::CNT_RING]           = l.l04;
    hit[fvdc_pkg::CNT_RING_C03]       = l.l04 && l.l03;
    hit[fvdc_pkg::CNT_DIAMOND]        = l.l14 && l.l03;
    hit[fvdc_pkg::CNT_RING_C03_24]    = l.l04 && l.l03 && l.l24;
    hit[fvdc_pkg::CNT_RING_C02_24]    = l.l04 && l.l02 && l.l24;
    hit[fvdc_pkg::CNT_DIAMOND_C13]    = l.l14 && l.l03 && l.l13;
    hit[fvdc_pkg::CNT_RING_3C]        = l.l04 && l.l03 && l.l24 && l.l02;
    hit[fvdc_pkg::CNT_RING_C02_24_13] = l.l04 && l.l02 && l.l24 && l.l13;
    hit[fvdc_pkg::CNT_RING_4C]        = l.l04 && l.l03 && l.l24 && l.l02 && l.l13;
    hit[fvdc_pkg::CNT_COMPLETE]       = l.l04 && l.l03 && l.l24 && l.l02 && l.l13
                                        && l.l14;
    hit[fvdc_pkg::CNT_SAMPLES]        = 1'b1;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cnt
    // Advance on a hit, hold at all ones
    assign cnt_d[i] = (take && hit[i] && (cnt_q[i] != '1))
                      ? cnt_q[i] + COUNT_BITS'(1) : cnt_q[i];

    if (COUNT_BITS >= OW) begin : g_trunc
      assign count_o[i] = cnt_q[i][OW-1:0];
    end else begin : g_zext
      assign count_o[i] = {{(OW-COUNT_BITS){1'b0}}, cnt_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (take) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  a_sample_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> ((cnt_q[fvdc_pkg::CNT_SAMPLES] ==
               $past(cnt_q[fvdc_pkg::CNT_SAMPLES]) + COUNT_BITS'(1))
              || (cnt_q[fvdc_pkg::CNT_SAMPLES] == '1)))
    else $error("sample counter did not advance on an item");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> $stable(cnt_q))
    else $error("counters moved without an item");

  a_nesting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[fvdc_pkg::CNT_COMPLETE] <= cnt_q[fvdc_pkg::CNT_RING_4C])
    && (cnt_q[fvdc_pkg::CNT_RING_4C] <= cnt_q[fvdc_pkg::CNT_RING_3C])
    && (cnt_q[fvdc_pkg::CNT_RING_3C] <= cnt_q[fvdc_pkg::CNT_RING_C03_24])
    && (cnt_q[fvdc_pkg::CNT_RING_C03_24] <= cnt_q[fvdc_pkg::CNT_RING_C03])
    && (cnt_q[fvdc_pkg::CNT_RING_C03] <= cnt_q[fvdc_pkg::CNT_RING])
    && (cnt_q[fvdc_pkg::CNT_RING_C02_24_13] <= cnt_q[fvdc_pkg::CNT_RING_C02_24])
    && (cnt_q[fvdc_pkg::CNT_RING_C02_24] <= cnt_q[fvdc_pkg::CNT_RING])
    && (cnt_q[fvdc_pkg::CNT_DIAMOND_C13] <= cnt_q[fvdc_pkg::CNT_DIAMOND])
    && (cnt_q[fvdc_pkg::CNT_DIAMOND] <= cnt_q[fvdc_pkg::CNT_SAMPLES])
    && (cnt_q[fvdc_pkg::CNT_RING] <= cnt_q[fvdc_pkg::CNT_SAMPLES]))
    else $error("sub-diagram counter exceeds its parent");

endmodule
